@@ hdl/sm3_pkg.sv @@
package sm3_pkg;

   localparam int unsigned WordWidth  = 32;
   localparam int unsigned BlockWords = 16;
   localparam int unsigned Rounds     = 64;
   localparam int unsigned DigestWords = 8;

   localparam logic [31:0] TjLow  = 32'h79cc4519;
   localparam logic [31:0] TjHigh = 32'h7a879d8a;
   localparam logic [31:0] PadWord = 32'h80000000;
   localparam logic [7:0]  PadByte = 8'h80;

   localparam logic [255:0] SM3_IV = {
      32'h7380166f, 32'h4914b2b9, 32'h172442d7, 32'hda8a0600,
      32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e};

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROUND,
      ST_PAD,
      ST_LEN_HI,
      ST_LEN_LO,
      ST_EMIT
   } state_type;

   // source for a word written into the block buffer
   typedef enum logic [1:0] {
      SRC_INPUT,
      SRC_ZERO,
      SRC_LEN_HI,
      SRC_LEN_LO
   } wsrc_type;

   typedef struct packed {
      logic     put;        // write one word into the block buffer
      wsrc_type src;
      logic     use_pad;    // merge pad into input word, or write the pad word for a zero word
      logic     add_len;    // accumulate length of accepted word
      logic     start;      // load working vars/window, begin rounds
      logic     round;      // run one round
      logic     finish;     // fold working vars into chaining value
      logic     reset_msg;  // restore IV, clear length and fill
   } cmd_type;

   typedef struct packed {
      logic       block_full;  // fill index at the last slot of the block
      logic [3:0] fill;
      logic       last_round;
   } stat_type;

   function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
      logic [63:0] d;
      d = {x, x} << n;
      return d[63:32];
   endfunction

   function automatic logic [31:0] p0(input logic [31:0] x);
      return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
   endfunction

   function automatic logic [31:0] p1(input logic [31:0] x);
      return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
   endfunction

endpackage

@@ hdl/sm3_hash_stream_top.sv @@
// SM3 streaming hash. Message words enter on req_ (big-endian, byte_count
// valid bytes, last_word ends the message); eight digest words leave on
// rsp_ in order, digest_done on the eighth. Words are taken only while idle.
// A full 16-word block is loaded and then run through the rounds of the
// single round unit, while words are not taken; padding writes pad and zero
// words and then the two length words, and may add a second block.
// A digest word is held while rsp_stall is high, and no new word is taken
// until the eighth digest word has gone out.
module sm3_hash_stream_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_data_word,
   input  logic [2:0]  req_byte_count,
   input  logic        req_last_word,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_digest_done
);

   sm3_pkg::cmd_type  cmd;
   sm3_pkg::stat_type stat;
   logic [2:0]        idx;

   sm3_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .req_byte_count, .req_last_word,
      .rsp_valid, .rsp_stall, .emit_index(idx), .cmd, .stat);

   sm3_datapath u_dp (
      .clock, .reset, .cmd, .stat, .in_word(req_data_word),
      .in_count(req_byte_count), .in_last(req_last_word),
      .emit_index(idx), .digest_out(rsp_digest_word));

   assign rsp_word_index  = idx;
   assign rsp_digest_done = (idx == 3'd7);

   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> req_stall)
      else $error("input taken during digest");
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_word_index)
                                    && $stable(rsp_digest_word)))
      else $error("stalled digest word changed");
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_digest_done) |=> !rsp_valid)
      else $error("extra digest word");

endmodule

@@ hdl/sm3_datapath.sv @@
module sm3_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  sm3_pkg::cmd_type      cmd,
   output sm3_pkg::stat_type     stat,
   input  logic [31:0]           in_word,
   input  logic [2:0]            in_count,
   input  logic                  in_last,
   input  logic [2:0]            emit_index,
   output logic [31:0]           digest_out
);

   logic [31:0] blk_ff [16];
   logic [31:0] win_ff [16];
   logic [31:0] v_ff   [8];
   logic [31:0] v_nxt  [8];
   logic [255:0] cv_ff, cv_in;
   logic [63:0] bits_ff, bits_in;
   logic [3:0]  fill_ff, fill_in;
   logic [5:0]  rnd_ff, rnd_in;
   logic [2:0]  cnt;
   logic [31:0] mask, pad, wr_word, wj, wk, wnew, tj, a12, ss1, ss2, ff, gg, tt1, tt2, t;

   always_comb begin
      cnt = (in_count > 3'd4) ? 3'd4 : in_count;
      if (!in_last) cnt = 3'd4;
      case (cnt)
         3'd0: begin mask = 32'h0; pad = 32'h80000000; end
         3'd1: begin mask = 32'hff000000; pad = 32'h00800000; end
         3'd2: begin mask = 32'hffff0000; pad = 32'h00008000; end
         3'd3: begin mask = 32'hffffff00; pad = 32'h00000080; end
         default: begin mask = 32'hffffffff; pad = 32'h0; end
      endcase
      case (cmd.src)
         sm3_pkg::SRC_INPUT:  wr_word = cmd.use_pad ? ((in_word & mask) | pad) : in_word;
         sm3_pkg::SRC_LEN_HI: wr_word = bits_ff[63:32];
         sm3_pkg::SRC_LEN_LO: wr_word = bits_ff[31:0];
         default:             wr_word = 32'h0;
      endcase
      if (cmd.src == sm3_pkg::SRC_ZERO && cmd.use_pad) wr_word = sm3_pkg::PadWord;
   end

   // round datapath: window holds W[j..j+15] with W[j] at index 0
   always_comb begin
      wj  = win_ff[0];
      wk  = win_ff[4];
      t   = win_ff[0] ^ win_ff[7] ^ sm3_pkg::rotl(win_ff[13], 5'd15);
      wnew = sm3_pkg::p1(t) ^ sm3_pkg::rotl(win_ff[3], 5'd7) ^ win_ff[10];
      tj  = (rnd_ff < 6'd16) ? sm3_pkg::TjLow : sm3_pkg::TjHigh;
      a12 = sm3_pkg::rotl(v_ff[0], 5'd12);
      ss1 = sm3_pkg::rotl(a12 + v_ff[4] + sm3_pkg::rotl(tj, rnd_ff[4:0]), 5'd7);
      ss2 = ss1 ^ a12;
      if (rnd_ff < 6'd16) begin
         ff = v_ff[0] ^ v_ff[1] ^ v_ff[2];
         gg = v_ff[4] ^ v_ff[5] ^ v_ff[6];
      end else begin
         ff = (v_ff[0] & v_ff[1]) | (v_ff[0] & v_ff[2]) | (v_ff[1] & v_ff[2]);
         gg = (v_ff[4] & v_ff[5]) | (~v_ff[4] & v_ff[6]);
      end
      tt1 = ff + v_ff[3] + ss2 + (wj ^ wk);
      tt2 = gg + v_ff[7] + ss1 + wj;
   end

   // working vars after this round; the last round folds these into the chain
   always_comb begin
      v_nxt[0] = tt1;
      v_nxt[1] = v_ff[0];
      v_nxt[2] = sm3_pkg::rotl(v_ff[1], 5'd9);
      v_nxt[3] = v_ff[2];
      v_nxt[4] = sm3_pkg::p0(tt2);
      v_nxt[5] = v_ff[4];
      v_nxt[6] = sm3_pkg::rotl(v_ff[5], 5'd19);
      v_nxt[7] = v_ff[6];
   end

   always_comb begin
      bits_in = bits_ff;
      fill_in = fill_ff;
      cv_in   = cv_ff;
      rnd_in  = rnd_ff;
      if (cmd.add_len) bits_in = bits_ff + {58'd0, cnt, 3'd0};
      if (cmd.put) fill_in = fill_ff + 4'd1;
      if (cmd.start) rnd_in = 6'd0;
      else if (cmd.round) rnd_in = rnd_ff + 6'd1;
      if (cmd.finish)
         for (int i = 0; i < 8; i++) cv_in[255-32*i -: 32] = cv_ff[255-32*i -: 32] ^ v_nxt[i];
      if (cmd.reset_msg) begin
         cv_in = sm3_pkg::SM3_IV;
         bits_in = 64'd0;
         fill_in = 4'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cv_ff   <= sm3_pkg::SM3_IV;
         bits_ff <= 64'd0;
         fill_ff <= 4'd0;
         rnd_ff  <= 6'd0;
      end else begin
         cv_ff   <= cv_in;
         bits_ff <= bits_in;
         fill_ff <= fill_in;
         rnd_ff  <= rnd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.put) blk_ff[fill_ff] <= wr_word;
      if (cmd.start) begin
         for (int i = 0; i < 16; i++) win_ff[i] <= blk_ff[i];
         for (int i = 0; i < 8; i++) v_ff[i] <= cv_ff[255-32*i -: 32];
      end else if (cmd.round) begin
         for (int i = 0; i < 15; i++) win_ff[i] <= win_ff[i+1];
         win_ff[15] <= wnew;
         for (int i = 0; i < 8; i++) v_ff[i] <= v_nxt[i];
      end
   end

   assign stat.block_full = (fill_ff == 4'd15);
   assign stat.fill       = fill_ff;
   assign stat.last_round = (rnd_ff == 6'd63);
   assign digest_out      = cv_ff[255 - 32*emit_index -: 32];

endmodule

@@ hdl/sm3_ctrl.sv @@
module sm3_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [2:0]            req_byte_count,
   input  logic                  req_last_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [2:0]            emit_index,
   output sm3_pkg::cmd_type      cmd,
   input  sm3_pkg::stat_type     stat
);

   sm3_pkg::state_type state_ff, state_in, ret_ff, ret_in;
   logic [2:0] idx_ff, idx_in;
   logic       padded_ff, padded_in; // pad word already placed
   logic       acc;
   logic       start_ff;             // load cycle of the round state

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= sm3_pkg::ST_IDLE;
         ret_ff    <= sm3_pkg::ST_IDLE;
         idx_ff    <= 3'd0;
         padded_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         ret_ff    <= ret_in;
         idx_ff    <= idx_in;
         padded_ff <= padded_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      ret_in    = ret_ff;
      idx_in    = idx_ff;
      padded_in = padded_ff;
      cmd       = '0;
      cmd.src   = sm3_pkg::SRC_ZERO;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      acc       = 1'b0;
      case (state_ff)
         sm3_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            acc = req_valid;
            if (acc) begin
               cmd.put = 1'b1;
               cmd.src = sm3_pkg::SRC_INPUT;
               cmd.add_len = 1'b1;
               cmd.use_pad = req_last_word;
               padded_in = !(req_last_word && req_byte_count >= 3'd4);
               ret_in = req_last_word ? sm3_pkg::ST_PAD : sm3_pkg::ST_IDLE;
               if (stat.block_full) begin
                  state_in = sm3_pkg::ST_ROUND;
               end else if (req_last_word) begin
                  // pad merged into slot 13: the length fills the block
                  if (req_byte_count < 3'd4 && stat.fill == 4'd13)
                     state_in = sm3_pkg::ST_LEN_HI;
                  else
                     state_in = sm3_pkg::ST_PAD;
               end
            end
         end
         sm3_pkg::ST_ROUND: begin
            // first cycle loads (start), then 64 rounds
            cmd.round = 1'b1;
            if (stat.last_round) begin
               state_in = ret_ff;
            end
         end
         sm3_pkg::ST_PAD: begin
            cmd.put = 1'b1;
            cmd.src = sm3_pkg::SRC_ZERO;
            cmd.use_pad = !padded_ff;
            padded_in = 1'b1;
            if (stat.fill == 4'd13) state_in = sm3_pkg::ST_LEN_HI;
            else if (stat.block_full) begin
               state_in = sm3_pkg::ST_ROUND;
               ret_in = sm3_pkg::ST_PAD;
            end
         end
         sm3_pkg::ST_LEN_HI: begin
            cmd.put = 1'b1;
            cmd.src = sm3_pkg::SRC_LEN_HI;
            state_in = sm3_pkg::ST_LEN_LO;
         end
         sm3_pkg::ST_LEN_LO: begin
            cmd.put = 1'b1;
            cmd.src = sm3_pkg::SRC_LEN_LO;
            state_in = sm3_pkg::ST_ROUND;
            ret_in = sm3_pkg::ST_EMIT;
            idx_in = 3'd0;
         end
         sm3_pkg::ST_EMIT: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               idx_in = idx_ff + 3'd1;
               if (idx_ff == 3'd7) begin
                  cmd.reset_msg = 1'b1;
                  state_in = sm3_pkg::ST_IDLE;
                  ret_in = sm3_pkg::ST_IDLE;
               end
            end
         end
         default: state_in = sm3_pkg::ST_IDLE;
      endcase
      if (state_in == sm3_pkg::ST_ROUND && state_ff != sm3_pkg::ST_ROUND) begin
         cmd.round = 1'b0;
      end
      if (state_ff == sm3_pkg::ST_ROUND && stat.last_round) cmd.finish = 1'b1;
      // load working vars once the last block write has landed
      if (start_ff) begin
         cmd.start  = 1'b1;
         cmd.round  = 1'b0;
         cmd.finish = 1'b0;
      end
   end

   // start must see the completed buffer, so it is registered and comes in the cycle after the last write
   always_ff @(posedge clock) begin
      if (reset) start_ff <= 1'b0;
      else start_ff <= (state_in == sm3_pkg::ST_ROUND) && (state_ff != sm3_pkg::ST_ROUND);
   end
   assign emit_index = idx_ff;

endmodule
